// ===== hdl/set_mean_stddev_stderr_top_macros.svh =====
// Assertion macros shared by the set statistics block
`ifndef SET_MEAN_STDDEV_STDERR_TOP_MACROS_SVH
`define SET_MEAN_STDDEV_STDERR_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SMSS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smss check failed");

// Check that a condition implies another in the next cycle
`define SMSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smss check failed");

`endif

// ===== hdl/smss_pkg.sv =====
// Types, constants and helpers of the set statistics block
`default_nettype none
package smss_pkg;
   localparam int MAX_ITEMS = 1024;
   localparam int VALUE_FRAC_BITS = 8;
   localparam int CNT_W = 11;
   localparam int SUM_W = 26;
   localparam int SQ_W = 42;
   localparam int D_W = 54;
   localparam int N3_W = 31;
   localparam int ROOT_W = 27;
   localparam int GROUP_DIVISOR = 10000;

   typedef struct packed {
      logic [15:0] sample_value;
      logic [16:0] group_code;
      logic        set_last;
   } req_type;

   typedef struct packed {
      logic [10:0] kept_count;
      logic [15:0] mean_value;
      logic [15:0] std_deviation;
      logic [15:0] std_error;
      logic        empty_set;
      logic        capacity_overflow;
   } rsp_type;

   // Totals of one closed set
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sumsq;
      logic             ovf;
   } snap_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_DIV_MEAN, ST_SQRT_D,
      ST_DIV_SD, ST_DIV_SE, ST_SQRT_SE, ST_OUT
   } back_state_type;

   function automatic logic [15:0] sat16(input logic [D_W-1:0] v);
      return (v > D_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
   endfunction
endpackage
`default_nettype wire

// ===== hdl/set_mean_stddev_stderr_top.sv =====
// Set statistics block: count, mean, standard deviation and standard error per set
//
// Samples stream in at one transfer per cycle; the front end filters them by
// group and updates count, sum and sum of squares. The last item of a set
// moves the totals into a two-entry queue and the front end carries on with
// the next set at once. The back end handles one set at a time (two multiply
// steps, three 54-step divisions on one shared divider, two 27-step square
// roots on one shared root unit; an empty set skips to the output); while
// two closed sets wait in the queue the input stalls until the back end takes
// one. Results leave through an output register with valid and ready.
`default_nettype none
`include "set_mean_stddev_stderr_top_macros.svh"
module set_mean_stddev_stderr_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [3:0]        csr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire smss_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output smss_pkg::rsp_type      rsp_data
);
   import smss_pkg::*;

   logic     q_push, q_full, q_pop, q_valid;
   snap_type q_in, q_out;

   smss_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_data,
      .req_valid, .req_ready, .req_data,
      .q_full, .q_push, .q_data(q_in)
   );

   smss_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .valid(q_valid), .pop_data(q_out)
   );

   smss_back u_back (
      .clock, .reset, .q_valid, .q_data(q_out), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   `SMSS_ASSERT_SAME(a_no_push_full, q_push, !q_full)
   `SMSS_ASSERT_SAME(a_empty_zero, rsp_valid && rsp_data.empty_set, rsp_data.mean_value == '0)
   `SMSS_ASSERT_SAME(a_nonempty_count, rsp_valid && !rsp_data.empty_set, rsp_data.kept_count != '0)
   `SMSS_ASSERT_NEXT(a_pop_needs_entry, q_pop && !q_push, !q_full)
endmodule
`default_nettype wire

// ===== hdl/smss_front.sv =====
// Front end: group filter and running count, sum and sum of squares
`default_nettype none
module smss_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [3:0]        csr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire smss_pkg::req_type req_data,
   input  wire logic              q_full,
   output logic                   q_push,
   output smss_pkg::snap_type     q_data
);
   import smss_pkg::*;

   logic [3:0]       sel_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             ovf_ff, ovf_in;
   logic [17:0]      lo_bound, hi_bound, code18;
   logic             keep, take;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   // Classify: group range check instead of a division
   always_comb begin
      lo_bound = 18'(sel_ff) * 18'(GROUP_DIVISOR);
      hi_bound = lo_bound + 18'(GROUP_DIVISOR);
      code18   = {1'b0, req_data.group_code};
      keep     = (sel_ff == 4'd0) || ((code18 >= lo_bound) && (code18 < hi_bound));
   end

   // Accumulate kept samples up to capacity
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      ovf_in = ovf_ff;
      if (keep) begin
         if (cnt_ff >= CNT_W'(MAX_ITEMS)) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = sum_ff + SUM_W'(req_data.sample_value);
            sq_in  = sq_ff + SQ_W'(32'(req_data.sample_value) *
                                   32'(req_data.sample_value));
         end
      end
   end

   assign q_push = take && req_data.set_last;
   assign q_data = '{count: cnt_in, sum: sum_in, sumsq: sq_in, ovf: ovf_in};

   // Hold config; advance or clear totals per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
         ovf_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) sel_ff <= csr_data;
         if (q_push) begin
            cnt_ff <= '0;
            sum_ff <= '0;
            sq_ff  <= '0;
            ovf_ff <= 1'b0;
         end else if (take) begin
            cnt_ff <= cnt_in;
            sum_ff <= sum_in;
            sq_ff  <= sq_in;
            ovf_ff <= ovf_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== hdl/smss_queue.sv =====
// Two-entry queue of closed set totals
`default_nettype none
module smss_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire smss_pkg::snap_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output smss_pkg::snap_type      pop_data
);
   import smss_pkg::*;

   snap_type    mem_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  fill_ff;

   assign full     = (fill_ff == 2'd2);
   assign valid    = (fill_ff != 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

// ===== hdl/smss_back.sv =====
// Back end: products, shared divider and square root, result register
`default_nettype none
module smss_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire smss_pkg::snap_type q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output smss_pkg::rsp_type       rsp_data
);
   import smss_pkg::*;

   back_state_type st_ff, st_in;
   logic [5:0]        cnt_ff;
   snap_type          s_ff;
   logic [31:0]       plo_ff, phi_ff;
   logic [51:0]       s2_ff;
   logic [21:0]       n2_ff;
   logic [D_W-1:0]    d_ff;
   logic [N3_W-1:0]   n3_ff;
   logic [15:0]       mean_ff, sd_ff, se_ff;
   logic [D_W-1:0]    dvd_ff, dvd_nx;
   logic [N3_W-1:0]   dvs_ff, rem_ff, rem_nx;
   logic [N3_W:0]     rem_sh;
   logic [D_W-1:0]    rad_ff;
   logic [28:0]       srem_ff, srem_nx;
   logic [30:0]       srem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_nx;
   logic              div_ge, sq_ge, div_last, sq_last, out_free;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // One divider step: restoring, one quotient bit
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[D_W-1]};
      div_ge = rem_sh >= {1'b0, dvs_ff};
      rem_nx = div_ge ? N3_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[N3_W-1:0];
      dvd_nx = {dvd_ff[D_W-2:0], div_ge};
   end

   // One square root step: one root bit
   always_comb begin
      srem_sh = {srem_ff, rad_ff[D_W-1:D_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      sq_ge   = srem_sh >= trial;
      srem_nx = sq_ge ? 29'(srem_sh - trial) : srem_sh[28:0];
      root_nx = {root_ff[ROOT_W-2:0], sq_ge};
   end

   assign div_last  = (cnt_ff == 6'(D_W - 1));
   assign sq_last   = (cnt_ff == 6'(ROOT_W - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state and queue pop
   always_comb begin
      st_in = st_ff;
      q_pop = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               st_in = ST_MUL1;
            end
         end
         ST_MUL1:     st_in = (s_ff.count == '0) ? ST_OUT : ST_MUL2;
         ST_MUL2:     st_in = ST_DIV_MEAN;
         ST_DIV_MEAN: if (div_last) st_in = ST_SQRT_D;
         ST_SQRT_D:   if (sq_last)  st_in = ST_DIV_SD;
         ST_DIV_SD:   if (div_last) st_in = ST_DIV_SE;
         ST_DIV_SE:   if (div_last) st_in = ST_SQRT_SE;
         ST_SQRT_SE:  if (sq_last)  st_in = ST_OUT;
         ST_OUT:      if (out_free) st_in = ST_IDLE;
         default:     st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
   end

   // Datapath: load, multiply, iterate
   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: if (q_valid) s_ff <= q_data;
         ST_MUL1: begin
            plo_ff  <= 32'(s_ff.count) * 32'(s_ff.sumsq[20:0]);
            phi_ff  <= 32'(s_ff.count) * 32'(s_ff.sumsq[41:21]);
            s2_ff   <= 52'(s_ff.sum) * 52'(s_ff.sum);
            n2_ff   <= 22'(s_ff.count) * 22'(s_ff.count);
            mean_ff <= '0;
            sd_ff   <= '0;
            se_ff   <= '0;
         end
         ST_MUL2: begin
            d_ff   <= D_W'(plo_ff) + {1'b0, phi_ff, 21'b0} - D_W'(s2_ff);
            n3_ff  <= N3_W'(33'(n2_ff) * 33'(s_ff.count));
            dvd_ff <= D_W'(s_ff.sum);
            dvs_ff <= N3_W'(s_ff.count);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV_MEAN: begin
            if (div_last) begin
               mean_ff <= sat16(dvd_nx);
               rad_ff  <= d_ff;
               srem_ff <= '0;
               root_ff <= '0;
               cnt_ff  <= '0;
            end else begin
               dvd_ff <= dvd_nx;
               rem_ff <= rem_nx;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ST_SQRT_D: begin
            if (sq_last) begin
               dvd_ff <= D_W'(root_nx);
               dvs_ff <= N3_W'(s_ff.count);
               rem_ff <= '0;
               cnt_ff <= '0;
            end else begin
               rad_ff  <= rad_ff << 2;
               srem_ff <= srem_nx;
               root_ff <= root_nx;
               cnt_ff  <= cnt_ff + 1'b1;
            end
         end
         ST_DIV_SD: begin
            if (div_last) begin
               sd_ff  <= sat16(dvd_nx);
               dvd_ff <= d_ff;
               dvs_ff <= n3_ff;
               rem_ff <= '0;
               cnt_ff <= '0;
            end else begin
               dvd_ff <= dvd_nx;
               rem_ff <= rem_nx;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ST_DIV_SE: begin
            if (div_last) begin
               rad_ff  <= dvd_nx;
               srem_ff <= '0;
               root_ff <= '0;
               cnt_ff  <= '0;
            end else begin
               dvd_ff <= dvd_nx;
               rem_ff <= rem_nx;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ST_SQRT_SE: begin
            if (sq_last) begin
               se_ff <= sat16(D_W'(root_nx));
            end else begin
               rad_ff  <= rad_ff << 2;
               srem_ff <= srem_nx;
               root_ff <= root_nx;
               cnt_ff  <= cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_ff.kept_count        <= s_ff.count;
               rsp_ff.mean_value        <= mean_ff;
               rsp_ff.std_deviation     <= sd_ff;
               rsp_ff.std_error         <= se_ff;
               rsp_ff.empty_set         <= (s_ff.count == '0);
               rsp_ff.capacity_overflow <= s_ff.ovf;
            end
         end
         default: ;
      endcase
   end

   // Hold the result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (st_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire
